/* design/pwsf_pkg.sv */
// shared constants, types and codes for the paged word store
// no dependencies; imported by every other file of the block except pwsf_ram
package pwsf_pkg;

  localparam int PAGE_WORDS  = 128;
  localparam int FRAMES      = 4;
  localparam int TOTAL_WORDS = 4096;
  localparam int WORD_WIDTH  = 32;

  localparam int IDX_W      = 13;
  localparam int DATA_W     = 32;
  localparam int OFF_W      = $clog2(PAGE_WORDS);
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int WADDR_W    = $clog2(TOTAL_WORDS);
  localparam int PAGE_W     = WADDR_W - OFF_W;
  localparam int FMEM_AW    = FRAME_W + OFF_W;
  localparam int CNT_W      = OFF_W + 1;
  localparam int MAP_WORD_W = 32;
  localparam int MAP_BIT_W  = $clog2(MAP_WORD_W);
  localparam int MAP_ROWS   = TOTAL_WORDS / MAP_WORD_W;
  localparam int MAP_ROW_W  = $clog2(MAP_ROWS);

  localparam logic [IDX_W-1:0] LIMIT_RESET = IDX_W'(TOTAL_WORDS);

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [WORD_WIDTH-1:0]    word_t;
  typedef logic [PAGE_W-1:0]        page_t;
  typedef logic [OFF_W-1:0]         off_t;
  typedef logic [FRAME_W-1:0]       frame_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [MAP_ROW_W-1:0]     map_row_t;
  typedef logic [MAP_WORD_W-1:0]    map_word_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_UNWRITTEN  = 2'd1,
    STAT_RANGE      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WB,
    ST_LOAD,
    ST_ISSUE,
    ST_ACCESS,
    ST_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic      rd_en;
    logic      wr_en;
    map_row_t  row;
    map_word_t wr_data;
  } map_cmd_t;

endpackage

/* design/pwsf_ifs.sv */
// handshake channel interfaces: request, response and configuration write
// depends on pwsf_pkg
interface pwsf_req_if import pwsf_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  idx_t  element_index;
  data_t data_in;

  modport source(output valid, action, element_index, data_in, input ready);
  modport sink(input valid, action, element_index, data_in, output ready);
endinterface

interface pwsf_rsp_if import pwsf_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  data_t   read_data;
  logic    page_fault;
  logic    wrote_back;

  modport source(output valid, status, read_data, page_fault, wrote_back, input ready);
  modport sink(input valid, status, read_data, page_fault, wrote_back, output ready);
endinterface

interface pwsf_cfg_if import pwsf_pkg::*; ();
  logic valid;
  logic ready;
  idx_t data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

/* design/pwsf_ram.sv */
// generic single-clock ram, one write port and one registered read port
// no dependencies
module pwsf_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/pwsf_wmap.sv */
// written-bit map, one bit per word packed into rows, with a clearing pass after reset
// depends on pwsf_pkg
module pwsf_wmap import pwsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  map_cmd_t  cmd,
  output map_word_t rd_data,
  output logic      busy
);

  map_word_t mem [MAP_ROWS];
  map_row_t  clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == map_row_t'(MAP_ROWS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_row] <= '0;
    end else if (cmd.wr_en) begin
      mem[cmd.row] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.row];
    end
  end

endmodule

/* design/pwsf_ctrl.sv */
// access sequencer: range and written checks, frame table, page copy sweeps, result register
// depends on pwsf_pkg; drives the frame ram, the backing ram and the written map
module pwsf_ctrl import pwsf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  idx_t               in_index,
  input  data_t              in_data,
  input  idx_t               limit,
  input  logic               map_busy,
  output map_cmd_t           map_cmd,
  input  map_word_t          map_rd_data,
  output logic               fm_we,
  output logic [FMEM_AW-1:0] fm_waddr,
  output word_t              fm_wdata,
  output logic [FMEM_AW-1:0] fm_raddr,
  input  word_t              fm_rdata,
  output logic               bk_we,
  output logic [WADDR_W-1:0] bk_waddr,
  output word_t              bk_wdata,
  output logic [WADDR_W-1:0] bk_raddr,
  input  word_t              bk_rdata,
  output logic               out_valid,
  input  logic               out_ready,
  output status_t            out_status,
  output data_t              out_rdata,
  output logic               out_fault,
  output logic               out_wb
);

  ctrl_state_t state, state_next;

  // latched request
  logic  act_wr;
  idx_t  idx;
  word_t wdata;

  // frame table
  page_t frame_page [FRAMES];
  logic  frame_dirty [FRAMES];
  frame_t ptr;

  frame_t fr;
  cnt_t   cnt;
  logic   wb_pend, ld_pend;
  off_t   pend_off;

  status_t res_status;
  data_t   res_rdata;
  logic    res_fault, res_wb;

  logic   accept, sweep_end, out_load;
  logic   chk_oor, chk_unwr, hit;
  frame_t hit_f;
  page_t  page;
  off_t   off;

  assign page = idx[WADDR_W-1:OFF_W];
  assign off  = idx[OFF_W-1:0];

  assign in_ready  = (state == ST_IDLE) && !map_busy;
  assign accept    = in_valid && in_ready;
  assign sweep_end = (cnt == cnt_t'(PAGE_WORDS));
  assign out_load  = (state == ST_RESP) && (!out_valid || out_ready);

  assign chk_oor  = (idx >= limit);
  assign chk_unwr = !act_wr && !map_rd_data[idx[MAP_BIT_W-1:0]];

  always_comb begin
    hit   = 1'b0;
    hit_f = '0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (frame_page[f] == page) begin
        hit   = 1'b1;
        hit_f = frame_t'(f);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    map_cmd.rd_en   = 1'b0;
    map_cmd.wr_en   = 1'b0;
    map_cmd.row     = idx[WADDR_W-1:MAP_BIT_W];
    map_cmd.wr_data = map_rd_data | (map_word_t'(1) << idx[MAP_BIT_W-1:0]);
    fm_we    = ld_pend;
    fm_waddr = {fr, pend_off};
    fm_wdata = bk_rdata;
    fm_raddr = {fr, off};
    bk_we    = wb_pend;
    bk_waddr = {frame_page[fr], pend_off};
    bk_wdata = fm_rdata;
    bk_raddr = {page, cnt[OFF_W-1:0]};
    unique case (state)
      ST_IDLE: begin
        map_cmd.rd_en = accept;
        map_cmd.row   = in_index[WADDR_W-1:MAP_BIT_W];
        if (accept) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        fm_raddr = {hit_f, off};
        if (chk_oor || chk_unwr) begin
          state_next = ST_RESP;
        end else if (hit) begin
          state_next = ST_ACCESS;
        end else if (frame_dirty[ptr]) begin
          state_next = ST_WB;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_WB: begin
        fm_raddr = {fr, cnt[OFF_W-1:0]};
        if (sweep_end) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sweep_end) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_next = ST_ACCESS;
      end
      ST_ACCESS: begin
        if (act_wr) begin
          fm_we         = 1'b1;
          fm_waddr      = {fr, off};
          fm_wdata      = wdata;
          map_cmd.wr_en = 1'b1;
        end
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // frame table and sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < FRAMES; f++) begin
        frame_page[f]  <= page_t'(f);
        frame_dirty[f] <= 1'b0;
      end
      ptr       <= '0;
      wb_pend   <= 1'b0;
      ld_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wb_pend <= (state == ST_WB) && !sweep_end;
      ld_pend <= (state == ST_LOAD) && !sweep_end;
      if (state == ST_LOAD && sweep_end) begin
        frame_page[fr]  <= page;
        frame_dirty[fr] <= 1'b0;
        ptr <= (ptr == frame_t'(FRAMES - 1)) ? '0 : ptr + 1'b1;
      end
      if (state == ST_ACCESS && act_wr) begin
        frame_dirty[fr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_off <= cnt[OFF_W-1:0];
    if (state == ST_WB || state == ST_LOAD) begin
      cnt <= sweep_end ? '0 : cnt + 1'b1;
    end
    if (accept) begin
      act_wr <= in_action;
      idx    <= in_index;
      wdata  <= word_t'(in_data);
    end
    if (state == ST_CHECK) begin
      cnt       <= '0;
      res_rdata <= '0;
      if (chk_oor) begin
        res_status <= STAT_RANGE;
        res_fault  <= 1'b0;
        res_wb     <= 1'b0;
      end else if (chk_unwr) begin
        res_status <= STAT_UNWRITTEN;
        res_fault  <= 1'b0;
        res_wb     <= 1'b0;
      end else if (hit) begin
        res_status <= STAT_OK;
        res_fault  <= 1'b0;
        res_wb     <= 1'b0;
        fr         <= hit_f;
      end else begin
        res_status <= STAT_OK;
        fr         <= ptr;
        res_fault  <= 1'b1;
        res_wb     <= frame_dirty[ptr];
      end
    end
    if (state == ST_ACCESS && !act_wr) begin
      res_rdata <= data_t'(fm_rdata[DATA_W-1:0]);
    end
    if (out_load) begin
      out_status <= res_status;
      out_rdata  <= res_rdata;
      out_fault  <= res_fault;
      out_wb     <= res_wb;
    end
  end

endmodule

/* design/paged_word_store_fifo_frames.sv */
// Paged word store with FIFO frame replacement. A 4096-word store is split into
// 128-word pages; four resident frames sit in a 512-word frame ram in front of a
// 4096-word backing ram, and a packed written-bit map (128 rows of 32 bits) tracks
// which words were ever written. Items are handled one at a time by a sequencer.
// A hit, or any access whose page is resident, passes from the accepting edge
// to the result through accept, check of range and written bit plus tag compare,
// frame ram access and result register. Out-of-range accesses and reads of
// unwritten words skip the frame ram access. A miss on a clean frame adds the page
// load sweep through the backing ram read port; a miss on a dirty frame first adds
// a copy-back sweep through the frame ram read port. After reset the written map
// is cleared one row a cycle, all 128 rows, during which no request is taken;
// configuration writes are taken at all times outside reset. The result sits in an
// output register, so a finished result may wait on the response channel while
// the next request is accepted.
// depends on pwsf_pkg, pwsf_ifs, pwsf_ram, pwsf_wmap and pwsf_ctrl
module paged_word_store_fifo_frames import pwsf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  pwsf_req_if.sink      req,
  pwsf_rsp_if.source    rsp,
  pwsf_cfg_if.sink      cfg
);

  // element_limit register, always ready for a write transaction
  idx_t element_limit;
  idx_t limit_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_limit <= LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      element_limit <= cfg.data;
    end
  end

  assign cfg.ready = 1'b1;

  // limit saturates at the store size
  assign limit_sat = (element_limit > LIMIT_RESET) ? LIMIT_RESET : element_limit;

  map_cmd_t           map_cmd;
  map_word_t          map_rd_data;
  logic               map_busy;

  logic               fm_we;
  logic [FMEM_AW-1:0] fm_waddr, fm_raddr;
  word_t              fm_wdata, fm_rdata;

  logic               bk_we;
  logic [WADDR_W-1:0] bk_waddr, bk_raddr;
  word_t              bk_wdata, bk_rdata;

  // resident frames, frame index in the upper address bits
  pwsf_ram #(
    .DEPTH (FRAMES * PAGE_WORDS),
    .WIDTH (WORD_WIDTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  // backing store, addressed by word index
  pwsf_ram #(
    .DEPTH (TOTAL_WORDS),
    .WIDTH (WORD_WIDTH)
  ) u_backing_ram (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  // written bits, read at accept and updated by read-modify-write on a write
  pwsf_wmap u_wmap (
    .clk     (clk),
    .rst     (rst),
    .cmd     (map_cmd),
    .rd_data (map_rd_data),
    .busy    (map_busy)
  );

  pwsf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_action   (req.action),
    .in_index    (req.element_index),
    .in_data     (req.data_in),
    .limit       (limit_sat),
    .map_busy    (map_busy),
    .map_cmd     (map_cmd),
    .map_rd_data (map_rd_data),
    .fm_we       (fm_we),
    .fm_waddr    (fm_waddr),
    .fm_wdata    (fm_wdata),
    .fm_raddr    (fm_raddr),
    .fm_rdata    (fm_rdata),
    .bk_we       (bk_we),
    .bk_waddr    (bk_waddr),
    .bk_wdata    (bk_wdata),
    .bk_raddr    (bk_raddr),
    .bk_rdata    (bk_rdata),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_status  (rsp.status),
    .out_rdata   (rsp.read_data),
    .out_fault   (rsp.page_fault),
    .out_wb      (rsp.wrote_back)
  );

endmodule
